@@ design/hcrp_pkg.sv @@
// shared types, codes and constants for the connect reply parser
package hcrp_pkg;

    // character codes
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_D0 = 8'd48;
    localparam logic [7:0] CH_D9 = 8'd57;

    // status code handling
    localparam int          CODE_W    = 10;
    localparam int          CODE_SUMW = 14;
    localparam logic [CODE_W-1:0] CODE_MAX     = 10'd1023;
    localparam logic [CODE_W-1:0] CODE_OK      = 10'd200;
    localparam logic [CODE_W-1:0] CODE_AUTH    = 10'd407;
    localparam logic [CODE_W-1:0] CODE_NOHOST  = 10'd404;
    localparam logic [CODE_W-1:0] CODE_FORBID  = 10'd403;
    localparam logic [CODE_W-1:0] CODE_UNAVAIL = 10'd503;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_ERROR = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        LERR_HOST    = 2'd0,
        LERR_REFUSED = 2'd1,
        LERR_READ    = 2'd2,
        LERR_OTHER   = 2'd3
    } link_err_t;

    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_OPEN    = 4'd1,
        EV_DATA    = 4'd2,
        EV_CLOSED  = 4'd3,
        EV_NEG     = 4'd4,
        EV_AUTH    = 4'd5,
        EV_HOST    = 4'd6,
        EV_REFUSED = 4'd7,
        EV_PCONN   = 4'd8,
        EV_READ    = 4'd9
    } event_t;

    // classified link event as it travels through the queue
    typedef struct packed {
        req_kind_t  kind;
        logic [7:0] data;
        link_err_t  err_kind;
        logic       is_cr;
        logic       is_lf;
        logic       is_sp;
        logic       is_digit;
        logic [3:0] digit;
    } item_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

@@ design/hcrp_front.sv @@
// front part: input handshake and byte classification
module hcrp_front
    import hcrp_pkg::*;
(
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    input  logic [1:0]  link_error_kind,
    input  q_status_t   q_status,
    output logic        push,
    output item_t       push_item
);

    logic [7:0] digit_off;

    // stall only when the queue has no room
    assign req_stall = q_status.full;
    assign push      = req_valid && !q_status.full;

    // classify the byte once so the back needs only flag tests
    assign digit_off = rx_byte - CH_D0;

    always_comb
    begin
        push_item.kind     = req_kind_t'(req_type);
        push_item.data     = rx_byte;
        push_item.err_kind = link_err_t'(link_error_kind);
        push_item.is_cr    = (rx_byte == CH_CR);
        push_item.is_lf    = (rx_byte == CH_LF);
        push_item.is_sp    = (rx_byte == CH_SP);
        push_item.is_digit = (rx_byte >= CH_D0) && (rx_byte <= CH_D9);
        push_item.digit    = digit_off[3:0];
    end

endmodule

@@ design/hcrp_queue.sv @@
// short fifo of classified items between front and back
module hcrp_queue
    import hcrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     pop_item,
    output q_status_t q_status
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // head entry and status
    assign pop_item           = mem_reg[rd_ptr_reg];
    assign q_status.full      = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.not_empty = (count_reg != '0);

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    // no push into a full queue without a pop, no pop from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full && !pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.not_empty)
        else $error("pop from empty queue");

    // pointers stay apart by the fill count, modulo the queue depth
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

@@ design/hcrp_back.sv @@
// back part: reply parse state machine and result register
module hcrp_back
    import hcrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  item_t      pop_item,
    output logic       pop,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [3:0] event_res,
    output logic [7:0] data_byte
);

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_PROTO = 6'b000010,
        PH_CODE  = 6'b000100,
        PH_MSG   = 6'b001000,
        PH_HDRS  = 6'b010000,
        PH_OPEN  = 6'b100000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                cr_reg, cr_next;
    logic                lhc_reg, lhc_next;
    logic [CODE_W-1:0]   value_reg, value_next;
    logic                bad_reg, bad_next;
    logic                res_valid_reg, res_valid_next;
    event_t              event_reg, event_next;
    logic [7:0]          data_reg, data_next;

    logic [CODE_SUMW-1:0] code_sum;
    logic [CODE_W-1:0]    code_sat;
    event_t               mapped_ev;
    logic                 parsing;

    // take the head item whenever the result register can load
    assign pop = q_status.not_empty && (!res_valid_reg || !res_stall);

    // decimal accumulate with saturation
    assign code_sum = CODE_SUMW'(value_reg) * CODE_SUMW'(10) + CODE_SUMW'(pop_item.digit);
    assign code_sat = (code_sum > CODE_SUMW'(CODE_MAX)) ? CODE_MAX : code_sum[CODE_W-1:0];

    assign parsing = (phase_reg != PH_IDLE) && (phase_reg != PH_OPEN);

    // reply code to event
    always_comb
    begin
        if (bad_reg)
        begin
            mapped_ev = EV_NEG;
        end
        else if (value_reg == CODE_OK)
        begin
            mapped_ev = EV_OPEN;
        end
        else if (value_reg == CODE_AUTH)
        begin
            mapped_ev = EV_AUTH;
        end
        else if (value_reg == CODE_NOHOST)
        begin
            mapped_ev = EV_HOST;
        end
        else if (value_reg == CODE_UNAVAIL)
        begin
            mapped_ev = EV_REFUSED;
        end
        else
        begin
            // forbidden and every other code
            mapped_ev = EV_NEG;
        end
    end

    // parse state and event for the popped item
    always_comb
    begin
        phase_next = phase_reg;
        cr_next    = cr_reg;
        lhc_next   = lhc_reg;
        value_next = value_reg;
        bad_next   = bad_reg;
        event_next = EV_NONE;
        data_next  = 8'd0;
        if (pop)
        begin
            case (pop_item.kind)
                REQ_START:
                begin
                    phase_next = PH_PROTO;
                    cr_next    = 1'b0;
                    lhc_next   = 1'b0;
                    value_next = '0;
                    bad_next   = 1'b0;
                end
                REQ_BYTE:
                begin
                    if (phase_reg == PH_OPEN)
                    begin
                        event_next = EV_DATA;
                        data_next  = pop_item.data;
                    end
                    else if (parsing && cr_reg && pop_item.is_lf)
                    begin
                        // end of line at cr lf
                        cr_next = 1'b0;
                        if (lhc_reg)
                        begin
                            lhc_next   = 1'b0;
                            phase_next = PH_HDRS;
                            if (phase_reg == PH_PROTO || phase_reg == PH_CODE)
                            begin
                                bad_next = 1'b1;
                            end
                        end
                        else
                        begin
                            // blank line: empty first line or end of headers
                            event_next = (phase_reg == PH_HDRS) ? mapped_ev : EV_NEG;
                            phase_next = (phase_reg == PH_HDRS && mapped_ev == EV_OPEN)
                                         ? PH_OPEN : PH_IDLE;
                            lhc_next   = 1'b0;
                            value_next = '0;
                            bad_next   = 1'b0;
                        end
                    end
                    else if (parsing)
                    begin
                        // a held cr turns into content, then the new byte
                        cr_next = pop_item.is_cr;
                        if (cr_reg || !pop_item.is_cr)
                        begin
                            lhc_next = 1'b1;
                        end
                        if (cr_reg && phase_reg == PH_CODE)
                        begin
                            bad_next = 1'b1;
                        end
                        if (!pop_item.is_cr)
                        begin
                            if (phase_reg == PH_PROTO && pop_item.is_sp)
                            begin
                                phase_next = PH_CODE;
                            end
                            else if (phase_reg == PH_CODE)
                            begin
                                if (pop_item.is_sp)
                                begin
                                    phase_next = PH_MSG;
                                end
                                else if (pop_item.is_digit)
                                begin
                                    value_next = code_sat;
                                end
                                else
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                REQ_CLOSE:
                begin
                    event_next = (phase_reg == PH_OPEN) ? EV_CLOSED : EV_NEG;
                    phase_next = PH_IDLE;
                    cr_next    = 1'b0;
                    lhc_next   = 1'b0;
                    value_next = '0;
                    bad_next   = 1'b0;
                end
                REQ_ERROR:
                begin
                    if (phase_reg == PH_OPEN)
                    begin
                        event_next = EV_READ;
                    end
                    else if (pop_item.err_kind == LERR_HOST ||
                             pop_item.err_kind == LERR_REFUSED)
                    begin
                        event_next = EV_PCONN;
                    end
                    else if (pop_item.err_kind == LERR_READ)
                    begin
                        event_next = EV_NEG;
                    end
                    else
                    begin
                        event_next = EV_NONE;
                    end
                    phase_next = PH_IDLE;
                    cr_next    = 1'b0;
                    lhc_next   = 1'b0;
                    value_next = '0;
                    bad_next   = 1'b0;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result register valid: load on pop, clear when taken
    always_comb
    begin
        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cr_reg        <= 1'b0;
            lhc_reg       <= 1'b0;
            value_reg     <= '0;
            bad_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cr_reg        <= cr_next;
            lhc_reg       <= lhc_next;
            value_reg     <= value_next;
            bad_reg       <= bad_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            event_reg <= event_next;
            data_reg  <= data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign event_res = event_reg;
    assign data_byte = data_reg;

    // data byte is zero unless the beat carries data
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && event_res != EV_DATA) |-> data_byte == 8'd0)
        else $error("data byte set on non-data beat");

    // outside parsing all line state is clear
    a_clear_outside: assert property (@(posedge clk) disable iff (!rst_n)
        !parsing |-> (!cr_reg && !lhc_reg && value_reg == '0 && !bad_reg))
        else $error("parse state left over outside negotiation");

    // a tunnel open event leaves the block open
    a_open_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && event_next == EV_OPEN) |=> phase_reg == PH_OPEN)
        else $error("tunnel open without open phase");

    // data events only come from an open tunnel
    a_data_open: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && event_next == EV_DATA) |-> phase_reg == PH_OPEN)
        else $error("data event outside open tunnel");

endmodule

@@ design/http_connect_reply_parser.sv @@
// top level of the proxy connect reply parser
//
//   channel   direction  handshake            beat contents
//   req       in         req_valid/req_stall  req_type, rx_byte, link_error_kind
//   res       out        res_valid/res_stall  event_res, data_byte
//
// one beat in gives exactly one beat out, one beat per cycle sustained while res_stall is low
// the back state machine handles one queued item per cycle while the result
// register can load; an accepted input is written to the queue, then popped
// into the result register, and earlier items or res_stall can hold it queued
// reset clears the queue, the parse state and the result valid
// req_stall rises only when the four-entry queue is full; a stalled res
// holds its beat while the queue keeps taking input
module http_connect_reply_parser
    import hcrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] rx_byte,
    input  logic [1:0] link_error_kind,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [3:0] event_res,
    output logic [7:0] data_byte
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    item_t     push_item;
    item_t     pop_item;

    // input side
    hcrp_front u_front (
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_type        (req_type),
        .rx_byte         (rx_byte),
        .link_error_kind (link_error_kind),
        .q_status        (q_status),
        .push            (push),
        .push_item       (push_item)
    );

    // decoupling queue
    hcrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    // parse and result side
    hcrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_item  (pop_item),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .event_res (event_res),
        .data_byte (data_byte)
    );

endmodule
